// ===== hdl/clipped_glyph_blitter_macros.svh =====
// Assertion macros shared by the glyph blitter modules.
// Needs nothing else; included by the files that carry assertions.
`ifndef CLIPPED_GLYPH_BLITTER_MACROS_SVH
`define CLIPPED_GLYPH_BLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clipped_glyph_blitter: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clipped_glyph_blitter: assertion failed");

`endif

// ===== hdl/cgb_pkg.sv =====
// Types, constants and register indexes of the clipped glyph blitter.
// Depends on nothing; imported by every module of the block.
package cgb_pkg;

	localparam int PIX_PER_WORD = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CLIP_LEFT = 4'd0,
		REG_CLIP_RIGHT = 4'd1,
		REG_CLIP_TOP = 4'd2,
		REG_CLIP_BOTTOM = 4'd3,
		REG_FORE_COLOR = 4'd4,
		REG_FORE_ALPHA = 4'd5,
		REG_BACK_COLOR = 4'd6,
		REG_BACK_ALPHA = 4'd7
	} cgb_reg_t;

	localparam logic [15:0] CLIP_LEFT_RST = 16'h0000;
	localparam logic [15:0] CLIP_RIGHT_RST = 16'hFFFF;
	localparam logic [15:0] CLIP_TOP_RST = 16'h0000;
	localparam logic [15:0] CLIP_BOTTOM_RST = 16'hFFFF;
	localparam logic [15:0] FORE_COLOR_RST = 16'h0000;
	localparam logic [7:0] FORE_ALPHA_RST = 8'hFF;
	localparam logic [15:0] BACK_COLOR_RST = 16'h0000;
	localparam logic [7:0] BACK_ALPHA_RST = 8'h00;

	typedef struct packed {
		logic command;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [7:0] glyph_width;
		logic [7:0] glyph_height;
		logic [7:0] bitmap_byte;
	} cgb_in_t;

	typedef struct packed {
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [15:0] pixel_color;
		logic [7:0] pixel_alpha;
		logic last;
	} cgb_out_t;

	// One classified bitmap byte: x of its first pixel, its row, its bits in
	// pixel order (bit i is pixel i) and which pixels lie inside the glyph.
	typedef struct packed {
		logic [16:0] x0;
		logic [16:0] y;
		logic [PIX_PER_WORD-1:0] pix_bits;
		logic [PIX_PER_WORD-1:0] col_mask;
	} cgb_entry_t;

	typedef struct packed {
		logic [15:0] clip_left;
		logic [15:0] clip_right;
		logic [15:0] clip_top;
		logic [15:0] clip_bottom;
		logic [15:0] fore_color;
		logic [7:0] fore_alpha;
		logic [15:0] back_color;
		logic [7:0] back_alpha;
	} cgb_cfg_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} cgb_qstat_t;

endpackage

// ===== hdl/cgb_queue.sv =====
// Short flop-based queue of classified bitmap bytes between front and back.
// Depends on cgb_pkg and the assertion macro header.
`include "clipped_glyph_blitter_macros.svh"

module cgb_queue
	import cgb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cgb_entry_t push_entry,
	input logic pop,
	output cgb_entry_t head,
	output cgb_qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cgb_entry_t entry_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	always_comb begin
		stat.not_empty = (count_q != '0);
		stat.full = (count_q == CW'(DEPTH));
		head = entry_q[rd_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CGB_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`CGB_ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`CGB_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push && !pop, count_q != CW'(DEPTH))

endmodule

// ===== hdl/cgb_front.sv =====
// Front end: accepts input words, tracks the glyph walk and classifies bytes.
// Depends on cgb_pkg; feeds cgb_queue.
module cgb_front
	import cgb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cgb_in_t in_data,
	input cgb_qstat_t q_stat,
	output logic push,
	output cgb_entry_t push_entry
);

	logic [15:0] base_x_q;
	logic [15:0] base_y_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] col_q;
	logic [7:0] row_q;

	logic accept;
	logic active;
	logic [8:0] next_col;

	always_comb begin
		in_ready = !q_stat.full;
		accept = in_valid && in_ready;
		active = (width_q != '0) && (row_q < height_q);
		push = accept && (in_data.command == CMD_BYTE) && active;
		next_col = {1'b0, col_q} + 9'(PIX_PER_WORD);
		push_entry.x0 = {1'b0, base_x_q} + 17'(col_q);
		push_entry.y = {1'b0, base_y_q} + 17'(row_q);
		for (int i = 0; i < PIX_PER_WORD; i++) begin
			push_entry.pix_bits[i] = in_data.bitmap_byte[PIX_PER_WORD-1-i];
			push_entry.col_mask[i] = ({1'b0, col_q} + 9'(i)) < {1'b0, width_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			width_q <= '0;
			height_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (in_data.command == CMD_START) begin
				base_x_q <= in_data.origin_x;
				base_y_q <= in_data.origin_y;
				width_q <= in_data.glyph_width;
				height_q <= in_data.glyph_height;
				col_q <= '0;
				row_q <= '0;
			end else if (active) begin
				// Every byte of a row is consumed, even past the right clip edge.
				if (next_col >= {1'b0, width_q}) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= next_col[7:0];
				end
			end
		end
	end

endmodule

// ===== hdl/cgb_back.sv =====
// Back end: clips a queued byte, sends one pixel/cycle unless stalled.
// Depends on cgb_pkg and the assertion macro header; reads cgb_queue.
`include "clipped_glyph_blitter_macros.svh"

module cgb_back
	import cgb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cgb_cfg_t cfg,
	input cgb_entry_t head,
	input cgb_qstat_t q_stat,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output cgb_out_t out_data
);

	localparam int IW = $clog2(PIX_PER_WORD);

	logic [PIX_PER_WORD-1:0] mask_q;
	logic [PIX_PER_WORD-1:0] bits_q;
	logic [16:0] x0_q;
	logic [15:0] y_q;
	cgb_out_t out_q;
	logic out_valid_q;

	logic [PIX_PER_WORD-1:0] load_mask;
	logic [PIX_PER_WORD-1:0] pick;
	logic [PIX_PER_WORD-1:0] remaining;
	logic [IW-1:0] idx;
	logic [16:0] xi;
	logic [16:0] pix_x;
	logic y_ok;
	logic out_free;
	logic advance;
	logic work_done;
	logic is_set;

	always_comb begin
		// A pixel is kept when it lies in the glyph, on screen, inside the
		// window, and is a set bit or a background bit with nonzero alpha.
		y_ok = (head.y <= 17'h0FFFF) && (head.y >= {1'b0, cfg.clip_top})
			&& (head.y <= {1'b0, cfg.clip_bottom});
		for (int i = 0; i < PIX_PER_WORD; i++) begin
			xi = head.x0 + 17'(i);
			load_mask[i] = head.col_mask[i] && y_ok && (xi <= 17'h0FFFF)
				&& (xi >= {1'b0, cfg.clip_left}) && (xi <= {1'b0, cfg.clip_right})
				&& (head.pix_bits[i] || (cfg.back_alpha != '0));
		end

		pick = mask_q & (~mask_q + 1'b1);
		remaining = mask_q & ~pick;
		idx = '0;
		for (int i = 0; i < PIX_PER_WORD; i++) begin
			if (pick[i]) begin
				idx = IW'(i);
			end
		end
		is_set = bits_q[idx];
		pix_x = x0_q + 17'(idx);

		out_free = !out_valid_q || out_ready;
		advance = (mask_q != '0) && out_free;
		work_done = (mask_q == '0) || (advance && (remaining == '0));
		pop = work_done && q_stat.not_empty;

		out_valid = out_valid_q;
		out_data = out_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bits_q <= head.pix_bits;
			x0_q <= head.x0;
			y_q <= head.y[15:0];
		end
		if (advance) begin
			out_q.pixel_x <= pix_x[15:0];
			out_q.pixel_y <= y_q;
			out_q.pixel_color <= is_set ? cfg.fore_color : cfg.back_color;
			out_q.pixel_alpha <= is_set ? cfg.fore_alpha : cfg.back_alpha;
			out_q.last <= (remaining == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= load_mask;
			end else if (advance) begin
				mask_q <= remaining;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CGB_ASSERT_NEXT(a_emit_shows, clk, arst_n, advance, out_valid_q)
	`CGB_ASSERT_IMPLIES(a_pick_onehot, clk, arst_n, advance, $onehot(pick))
	`CGB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !out_ready, out_valid_q && $stable(out_q))

endmodule

// ===== hdl/clipped_glyph_blitter.sv =====
// Path: with the queue empty and the back end idle, the first pixel of a bitmap word is
// registered in the queue, in the back end's byte registers and then in the output register.
// Throughput: one word per cycle in while the queue has room; the back sends one pixel per
// cycle if out_ready allows, up to 8 per word. Start words and ignored bytes are never queued.
// Reset: arst_n clears the glyph walk, the queue and the output stage at once and loads
// the configuration registers with their defaults; no clearing pass is needed.
module clipped_glyph_blitter
	import cgb_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cgb_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output cgb_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	cgb_cfg_t cfg_q;
	cgb_qstat_t q_stat;
	cgb_entry_t push_entry;
	cgb_entry_t head;
	logic push;
	logic pop;

	assign cfg_ready = 1'b1;

	// Writes to an index past the register list fall into the default arm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left <= CLIP_LEFT_RST;
			cfg_q.clip_right <= CLIP_RIGHT_RST;
			cfg_q.clip_top <= CLIP_TOP_RST;
			cfg_q.clip_bottom <= CLIP_BOTTOM_RST;
			cfg_q.fore_color <= FORE_COLOR_RST;
			cfg_q.fore_alpha <= FORE_ALPHA_RST;
			cfg_q.back_color <= BACK_COLOR_RST;
			cfg_q.back_alpha <= BACK_ALPHA_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLIP_LEFT: cfg_q.clip_left <= cfg_data;
				REG_CLIP_RIGHT: cfg_q.clip_right <= cfg_data;
				REG_CLIP_TOP: cfg_q.clip_top <= cfg_data;
				REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data;
				REG_FORE_COLOR: cfg_q.fore_color <= cfg_data;
				REG_FORE_ALPHA: cfg_q.fore_alpha <= cfg_data[7:0];
				REG_BACK_COLOR: cfg_q.back_color <= cfg_data;
				REG_BACK_ALPHA: cfg_q.back_alpha <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	cgb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_stat(q_stat),
		.push(push),
		.push_entry(push_entry)
	);

	cgb_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.stat(q_stat)
	);

	cgb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
